/* sv/bhsp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhsp_pkg
// Shared types, constants and the bcrypt base64 symbol lookup for the
// hash string parser.
// ----------------------------------------------------------------------------
package bhsp_pkg;

	localparam int NumWords = 6;

	// character positions with a fixed meaning
	localparam logic [5:0] PosDollar0  = 6'd0;
	localparam logic [5:0] PosTwo      = 6'd1;
	localparam logic [5:0] PosVariant  = 6'd2;
	localparam logic [5:0] PosDollar1  = 6'd3;
	localparam logic [5:0] PosTens     = 6'd4;
	localparam logic [5:0] PosOnes     = 6'd5;
	localparam logic [5:0] PosDollar2  = 6'd6;
	localparam logic [5:0] PosSaltPad  = 6'd28;
	localparam logic [5:0] PosHashBase = 6'd29;
	localparam logic [5:0] PosLast     = 6'd59;
	localparam logic [5:0] PosMax      = 6'd61;

	localparam logic [6:0] SymInvalid = 7'd64;
	localparam logic [6:0] CostMin    = 7'd4;
	localparam logic [6:0] CostMax    = 7'd31;

	localparam logic [7:0] ChDollar = 8'h24;
	localparam logic [7:0] ChTwo    = 8'h32;
	localparam logic [7:0] ChZero   = 8'h30;

	typedef logic [31:0] word_t;

	// per-character classification handed from the decoder to the core
	typedef struct packed {
		logic [6:0] sym;
		logic       is_digit;
		logic [3:0] digit_val;
		logic       is_dollar;
		logic       is_two;
		logic       is_variant;
	} char_info_t;

	// bcrypt base64 alphabet "./A-Za-z0-9", anything else maps to 64
	function automatic logic [6:0] sym_value(input logic [7:0] ch);
		logic [6:0] sym;
		sym = SymInvalid;
		if (ch == 8'h2E) begin
			sym = 7'd0;
		end else if (ch == 8'h2F) begin
			sym = 7'd1;
		end else if (ch inside {[8'h41:8'h5A]}) begin
			sym = 7'(ch - 8'h41) + 7'd2;
		end else if (ch inside {[8'h61:8'h7A]}) begin
			sym = 7'(ch - 8'h61) + 7'd28;
		end else if (ch inside {[8'h30:8'h39]}) begin
			sym = 7'(ch - 8'h30) + 7'd54;
		end
		return sym;
	endfunction

endpackage
`default_nettype wire

/* sv/bhsp_char_decode.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhsp_char_decode
// Classifies one raw character: base64 symbol value, decimal digit and
// the fixed prefix characters.
// ----------------------------------------------------------------------------
module bhsp_char_decode (
	input  wire logic [7:0]            char_code,
	output bhsp_pkg::char_info_t       info
);

	// symbol lookup and prefix compares
	always_comb begin
		info.sym        = bhsp_pkg::sym_value(char_code);
		info.is_digit   = (char_code inside {[8'h30:8'h39]});
		info.digit_val  = 4'(char_code - bhsp_pkg::ChZero);
		info.is_dollar  = (char_code == bhsp_pkg::ChDollar);
		info.is_two     = (char_code == bhsp_pkg::ChTwo);
		info.is_variant = (char_code inside {8'h61, 8'h78, 8'h79});
	end

endmodule
`default_nettype wire

/* sv/bhsp_parse_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhsp_parse_core
// Per-string state: position counter, format flag, cost digits and the
// decoded hash words. Produces the result seen at the end of a string.
// ----------------------------------------------------------------------------
module bhsp_parse_core (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step,
	input  wire logic                  eos,
	input  wire bhsp_pkg::char_info_t  info,
	output logic                       hash_ok,
	output logic [4:0]                 cost,
	output bhsp_pkg::word_t            words [bhsp_pkg::NumWords]
);

	logic [5:0]      pos_q;
	logic            fmt_q;
	logic [3:0]      tens_q;
	logic [4:0]      cost_q;
	logic [6:0]      prev_q;
	bhsp_pkg::word_t words_q [bhsp_pkg::NumWords];

	logic            fmt_n;
	logic [3:0]      tens_n;
	logic [4:0]      cost_n;
	bhsp_pkg::word_t words_n [bhsp_pkg::NumWords];

	logic [6:0] cost_sum;
	logic [4:0] sym_idx;
	logic [4:0] grp;
	logic [4:0] byte_idx;
	logic [7:0] byte_val;
	logic       byte_wr;

	// two-digit cost value
	assign cost_sum = 7'({3'b000, tens_q} * 7'd10) + {3'b000, info.digit_val};

	// base64 group decode: byte index and value for this symbol
	always_comb begin
		sym_idx  = 5'(pos_q - bhsp_pkg::PosHashBase);
		grp      = 5'({2'b00, sym_idx[4:2]} << 1) + {2'b00, sym_idx[4:2]};
		byte_idx = grp;
		byte_val = 8'h00;
		byte_wr  = 1'b0;
		case (sym_idx[1:0])
			2'd1: begin
				byte_val = 8'({prev_q, 2'b00}) | {6'b000000, info.sym[5:4]};
				byte_wr  = 1'b1;
			end
			2'd2: begin
				byte_idx = grp + 5'd1;
				byte_val = {prev_q[3:0], info.sym[5:2]};
				byte_wr  = 1'b1;
			end
			2'd3: begin
				byte_idx = grp + 5'd2;
				byte_val = {prev_q[1:0], 6'b000000} | {1'b0, info.sym};
				byte_wr  = 1'b1;
			end
			default: begin
				byte_wr = 1'b0;
			end
		endcase
	end

	// format checks and next state
	always_comb begin
		fmt_n  = fmt_q;
		tens_n = tens_q;
		cost_n = cost_q;
		for (int w = 0; w < bhsp_pkg::NumWords; w++) begin
			words_n[w] = words_q[w];
		end
		if (pos_q == bhsp_pkg::PosDollar0 || pos_q == bhsp_pkg::PosDollar1 ||
		    pos_q == bhsp_pkg::PosDollar2) begin
			if (!info.is_dollar) fmt_n = 1'b0;
		end else if (pos_q == bhsp_pkg::PosTwo) begin
			if (!info.is_two) fmt_n = 1'b0;
		end else if (pos_q == bhsp_pkg::PosVariant) begin
			if (!info.is_variant) fmt_n = 1'b0;
		end else if (pos_q == bhsp_pkg::PosTens) begin
			if (info.is_digit) tens_n = info.digit_val;
			else fmt_n = 1'b0;
		end else if (pos_q == bhsp_pkg::PosOnes) begin
			if (info.is_digit && cost_sum >= bhsp_pkg::CostMin &&
			    cost_sum <= bhsp_pkg::CostMax) begin
				cost_n = cost_sum[4:0];
			end else begin
				fmt_n = 1'b0;
			end
		end else if (pos_q <= bhsp_pkg::PosLast) begin
			if (info.sym == bhsp_pkg::SymInvalid) fmt_n = 1'b0;
			// padding bits of the salt and hash tails must be zero
			if (pos_q == bhsp_pkg::PosSaltPad && info.sym[3:0] != 4'h0) fmt_n = 1'b0;
			if (pos_q == bhsp_pkg::PosLast && info.sym[1:0] != 2'b00) fmt_n = 1'b0;
			if (pos_q >= bhsp_pkg::PosHashBase && byte_wr) begin
				words_n[byte_idx[4:2]][8 * (2'(2'd3 - byte_idx[1:0])) +: 8] = byte_val;
			end
		end else begin
			fmt_n = 1'b0;
		end
	end

	// result view of the updated state
	always_comb begin
		hash_ok = fmt_n && (pos_q == bhsp_pkg::PosLast);
		cost    = hash_ok ? cost_n : 5'd0;
		for (int w = 0; w < bhsp_pkg::NumWords; w++) begin
			words[w] = words_n[w];
		end
		words[bhsp_pkg::NumWords - 1][7:0] = 8'h00;
	end

	// state registers, cleared at the end of each string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= 6'd0;
			fmt_q  <= 1'b1;
			tens_q <= 4'd0;
			cost_q <= 5'd0;
			prev_q <= 7'd0;
			for (int w = 0; w < bhsp_pkg::NumWords; w++) begin
				words_q[w] <= '0;
			end
		end else if (step) begin
			if (eos) begin
				pos_q  <= 6'd0;
				fmt_q  <= 1'b1;
				tens_q <= 4'd0;
				cost_q <= 5'd0;
				prev_q <= 7'd0;
				for (int w = 0; w < bhsp_pkg::NumWords; w++) begin
					words_q[w] <= '0;
				end
			end else begin
				if (pos_q < bhsp_pkg::PosMax) pos_q <= pos_q + 6'd1;
				fmt_q  <= fmt_n;
				tens_q <= tens_n;
				cost_q <= cost_n;
				prev_q <= info.sym;
				for (int w = 0; w < bhsp_pkg::NumWords; w++) begin
					words_q[w] <= words_n[w];
				end
			end
		end
	end

endmodule
`default_nettype wire

/* sv/bcrypt_hash_string_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcrypt_hash_string_parser
// Checks a bcrypt hash string streamed one character per request and
// decodes its 23 hash bytes into six big-endian words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries char_code and end_of_string,
//   one character per request. The request with end_of_string set closes
//   the string and produces one result request on the output channel
//   (out_valid/out_ready): hash_ok, cost and word0..word5.
//   Throughput: one character per cycle while no closing character waits
//   for the result register. A closing character passes through the input
//   register, then the result register, before its result is valid.
//   A stalled receiver holds the result register; characters that do not
//   close a string keep flowing, and a closing character waits in the
//   input register until the result register is free.
//   Reset clears all per-string state and both valid flags; the block
//   accepts characters in the first cycle after reset.
//   Per-string state clears itself after every closing character.
// ----------------------------------------------------------------------------
module bcrypt_hash_string_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_code,
	input  wire logic        end_of_string,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             hash_ok,
	output logic [4:0]       cost,
	output logic [31:0]      word0,
	output logic [31:0]      word1,
	output logic [31:0]      word2,
	output logic [31:0]      word3,
	output logic [31:0]      word4,
	output logic [31:0]      word5
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eos_s1;
	logic       advance;

	bhsp_pkg::char_info_t info;
	logic                 ok_n;
	logic [4:0]           cost_n;
	bhsp_pkg::word_t      words_n [bhsp_pkg::NumWords];

	logic                 out_valid_q;
	logic                 ok_q;
	logic [4:0]           cost_q;
	bhsp_pkg::word_t      words_q [bhsp_pkg::NumWords];

	// a closing character needs room in the result register
	assign advance  = valid_s1 && (!eos_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_code;
			eos_s1  <= end_of_string;
		end
	end

	bhsp_char_decode u_decode (
		.char_code (char_s1),
		.info      (info)
	);

	bhsp_parse_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.eos     (eos_s1),
		.info    (info),
		.hash_ok (ok_n),
		.cost    (cost_n),
		.words   (words_n)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && eos_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && eos_s1) begin
			ok_q   <= ok_n;
			cost_q <= cost_n;
			for (int w = 0; w < bhsp_pkg::NumWords; w++) begin
				words_q[w] <= words_n[w];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign hash_ok   = ok_q;
	assign cost      = cost_q;
	assign word0     = words_q[0];
	assign word1     = words_q[1];
	assign word2     = words_q[2];
	assign word3     = words_q[3];
	assign word4     = words_q[4];
	assign word5     = words_q[5];

endmodule
`default_nettype wire
